// File: rtl/lvp_pkg.sv
package lvp_pkg;

  // Default configuration
  localparam int LVP_LENGTH_BITS = 16;
  localparam int LVP_QUEUE_DEPTH = 4;

  // Parser phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_HEADER   = 2'd1,
    PH_FINISHED = 2'd2
  } lvp_phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } lvp_kind_t;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SHORT   = 2'd1;
  localparam logic [1:0] ERR_HEADER  = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  // Results of one input transaction; two is set when a done follows the entry
  typedef struct packed {
    lvp_kind_t   kind;
    logic [14:0] index;
    logic [15:0] offset;
    logic [15:0] size;
    logic [16:0] consumed;
    logic [1:0]  err;
    logic        two;
  } lvp_bundle_t;

  // Round a 16-bit length up to a multiple of 4
  function automatic logic [16:0] align4(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd3;
    return {s[16:2], 2'b00};
  endfunction

endpackage

// File: rtl/lvp_front.sv
module lvp_front
  import lvp_pkg::*;
#(
  parameter int LENGTH_BITS = LVP_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        region_start,
  input  logic [15:0] region_length,
  output logic        push,
  output lvp_bundle_t push_data
);

  lvp_phase_t             phase, phase_next;
  logic                   little_endian;
  logic [15:0]            byte_position, byte_position_next;
  logic [LENGTH_BITS-1:0] total_length, total_length_next;
  logic [16:0]            next_offset, next_offset_next;
  logic [7:0]             held_byte, held_byte_next;
  logic [14:0]            slot_count, slot_count_next;

  logic [31:0]            len_wide;
  logic [31:0]            total_wide;
  logic [LENGTH_BITS-1:0] len_masked;
  logic [15:0]            word;
  logic [14:0]            slot;
  logic [16:0]            hdr_aligned;
  logic [16:0]            size_aligned;
  logic [17:0]            offset_sum;
  logic [31:0]            entry_end;

  assign len_wide     = 32'(region_length);
  assign len_masked   = len_wide[LENGTH_BITS-1:0];
  assign total_wide   = 32'(total_length);
  assign word         = little_endian ? {data_byte, held_byte} : {held_byte, data_byte};
  assign slot         = byte_position[15:1];
  assign hdr_aligned  = align4(word);
  assign size_aligned = align4(word);
  assign offset_sum   = {1'b0, next_offset} + {1'b0, size_aligned};
  assign entry_end    = 32'(next_offset) + 32'(word);

  // Hold the endianness register
  always_ff @(posedge clk) begin
    if (rst) begin
      little_endian <= 1'b1;
    end else if (cfg_wr_en) begin
      little_endian <= cfg_wr_data;
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      total_length  <= '0;
      next_offset   <= '0;
      held_byte     <= '0;
      slot_count    <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      total_length  <= total_length_next;
      next_offset   <= next_offset_next;
      held_byte     <= held_byte_next;
      slot_count    <= slot_count_next;
    end
  end

  // Classify the byte and build its results
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    total_length_next  = total_length;
    next_offset_next   = next_offset;
    held_byte_next     = held_byte;
    slot_count_next    = slot_count;
    push               = 1'b0;
    push_data          = '0;
    if (accept) begin
      if (region_start) begin
        total_length_next  = len_masked;
        byte_position_next = '0;
        next_offset_next   = '0;
        held_byte_next     = '0;
        slot_count_next    = '0;
        phase_next         = PH_HEADER;
        if (32'(len_masked) < 32'd4) begin
          push           = 1'b1;
          push_data.kind = KIND_ERROR;
          push_data.err  = ERR_SHORT;
          phase_next     = PH_FINISHED;
        end else begin
          // first byte of the region is always the low position
          held_byte_next     = data_byte;
          byte_position_next = 16'd1;
        end
      end else begin
        unique case (phase)
          PH_HEADER: begin
            byte_position_next = byte_position + 16'd1;
            if (!byte_position[0]) begin
              held_byte_next = data_byte;
            end else if (slot == 15'd0) begin
              // header length word
              if (word == 16'd0) begin
                push               = 1'b1;
                push_data.kind     = KIND_DONE;
                push_data.consumed = 17'd4;
                phase_next         = PH_FINISHED;
              end else if (32'(word) > total_wide || word[0]) begin
                push           = 1'b1;
                push_data.kind = KIND_ERROR;
                push_data.err  = ERR_HEADER;
                phase_next     = PH_FINISHED;
              end else begin
                slot_count_next  = word[15:1];
                next_offset_next = hdr_aligned;
                if (word[15:1] == 15'd1) begin
                  push               = 1'b1;
                  push_data.kind     = KIND_DONE;
                  push_data.consumed = hdr_aligned;
                  phase_next         = PH_FINISHED;
                end
              end
            end else begin
              // entry size word
              push = 1'b1;
              if (entry_end > total_wide) begin
                push_data.kind = KIND_ERROR;
                push_data.err  = ERR_OVERRUN;
                phase_next     = PH_FINISHED;
              end else begin
                push_data.kind   = KIND_ENTRY;
                push_data.index  = slot - 15'd1;
                push_data.offset = next_offset[15:0];
                push_data.size   = word;
                next_offset_next = offset_sum[16:0];
                if (({1'b0, slot} + 16'd1) >= {1'b0, slot_count}) begin
                  push_data.two      = 1'b1;
                  push_data.consumed = offset_sum[16:0];
                  phase_next         = PH_FINISHED;
                end
              end
            end
          end
          default: begin
            // drop bytes outside an open header
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/lvp_queue.sv
module lvp_queue
  import lvp_pkg::*;
#(
  parameter int DEPTH = LVP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lvp_bundle_t push_data,
  input  logic        pop,
  output lvp_bundle_t pop_data,
  output logic        full,
  output logic        empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lvp_bundle_t   slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Write the incoming transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/lvp_back.sv
module lvp_back
  import lvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lvp_bundle_t head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [14:0] entry_index,
  output logic [15:0] entry_offset,
  output logic [15:0] entry_size,
  output logic [16:0] consumed_bytes,
  output logic [1:0]  error_code,
  output logic        last_result
);

  logic second;
  logic load;
  logic first_of_two;

  assign load         = (!out_valid || !out_stall) && !empty;
  assign first_of_two = head.two && !second;
  assign pop          = load && !first_of_two;

  // Track which half of a two-result transaction goes out next
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= first_of_two;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (second) begin
        result_kind    <= KIND_DONE;
        entry_index    <= '0;
        entry_offset   <= '0;
        entry_size     <= '0;
        consumed_bytes <= head.consumed;
        error_code     <= ERR_NONE;
        last_result    <= 1'b1;
      end else begin
        result_kind    <= head.kind;
        entry_index    <= head.index;
        entry_offset   <= head.offset;
        entry_size     <= head.size;
        consumed_bytes <= head.two ? 17'd0 : head.consumed;
        error_code     <= head.err;
        last_result    <= !head.two;
      end
    end
  end

endmodule

// File: rtl/length_vector_parser.sv
// Results are written to the result queue as bytes are accepted, then to the
// output register. Throughput: one byte per cycle without in_stall; one result
// per cycle at the output without out_stall, so a header's last entry (entry plus
// done) is two results, absorbed by the queue. in_stall rises only while the
// result queue is full. Reset (rst, synchronous, active high) empties the queue
// and output, sets the parser idle and little_endian to 1.
module length_vector_parser
  import lvp_pkg::*;
#(
  parameter int LENGTH_BITS = LVP_LENGTH_BITS,
  parameter int QUEUE_DEPTH = LVP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        region_start,
  input  logic [15:0] region_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [14:0] entry_index,
  output logic [15:0] entry_offset,
  output logic [15:0] entry_size,
  output logic [16:0] consumed_bytes,
  output logic [1:0]  error_code,
  output logic        last_result
);

  lvp_bundle_t push_data, head;
  logic        push, pop, full, empty;
  logic        accept;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // Accept and classify bytes
  lvp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .accept       (accept),
    .data_byte    (data_byte),
    .region_start (region_start),
    .region_length(region_length),
    .push         (push),
    .push_data    (push_data)
  );

  // Buffer results between the two sides
  lvp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (head),
    .full     (full),
    .empty    (empty)
  );

  // Emit the results of each transaction one at a time
  lvp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .entry_index   (entry_index),
    .entry_offset  (entry_offset),
    .entry_size    (entry_size),
    .consumed_bytes(consumed_bytes),
    .error_code    (error_code),
    .last_result   (last_result)
  );

endmodule

// File: rtl/lvp_checker.sv
module lvp_checker
  import lvp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [15:0] entry_offset,
  input logic [16:0] consumed_bytes,
  input logic [1:0]  error_code,
  input logic        last_result
);

  // Hold a stalled result transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_kind) &&
      $stable(consumed_bytes) && $stable(error_code) && $stable(last_result)))
    else $error("stalled result changed");

  // Done and error close a transaction's results
  a_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_kind == KIND_DONE || result_kind == KIND_ERROR)) |-> last_result)
    else $error("done or error not marked last");

  // Error code only on error results
  a_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != KIND_ERROR) |-> (error_code == ERR_NONE))
    else $error("error code on non-error result");

  // Offsets and consumed counts stay word aligned
  a_align: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((entry_offset[1:0] == 2'b00) && (consumed_bytes[1:0] == 2'b00)))
    else $error("misaligned offset or consumed count");

endmodule

bind length_vector_parser lvp_checker u_lvp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .result_kind   (result_kind),
  .entry_offset  (entry_offset),
  .consumed_bytes(consumed_bytes),
  .error_code    (error_code),
  .last_result   (last_result)
);
